FILE: hdl/gasp_pkg.sv
// ----------------------------------------------------------------------------
// gasp_pkg: glyph atlas shelf packer shared definitions
// Field widths, codes, limits and the structs passed between the packer's
// placement logic and its top level.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int unsigned DIM_W      = 13;  // glyph and atlas dimensions
  localparam int unsigned COORD_W    = 12;  // result coordinates
  localparam int unsigned LAYER_W    = 8;
  localparam int unsigned CURSOR_Y_W = 14;

  localparam int unsigned MAX_LAYERS = 256;

  localparam logic [DIM_W-1:0] DIM_LIMIT        = 13'd4096;
  localparam logic [DIM_W-1:0] ATLAS_DIM_RESET  = 13'd1024;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_OVERSIZE  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_ATLAS_WIDTH  = 1'b0,
    REG_ATLAS_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]      cursor_x;
    logic [CURSOR_Y_W-1:0] cursor_y;
    logic [DIM_W-1:0]      shelf_height;
    logic [LAYER_W-1:0]    layer_index;
  } place_state_t;

  typedef struct packed {
    status_e              status;
    logic [COORD_W-1:0]   left_x;
    logic [COORD_W-1:0]   top_y;
    logic [COORD_W-1:0]   right_x;
    logic [COORD_W-1:0]   bottom_y;
    logic [LAYER_W-1:0]   layer_used;
  } place_result_t;

endpackage

FILE: hdl/glyph_atlas_shelf_packer.sv
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_packer: layered texture atlas shelf packer
// Places glyph rectangles left to right on shelves across atlas layers.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: each item carries a glyph width and height. Output stream:
//   one item per input, with the status code in tuser and the placed corners
//   and layer in tdata (all zero unless the glyph was placed).
//   The APB port sets the layer width (address 0) and height (address 4);
//   write them only while no item is in flight.
//   An item is taken into the input register, then moved into the result
//   register, which drives the output. One item per cycle is sustained
//   while the receiver is ready; the cursor update between those
//   registers is a few adds and compares, so consecutive items chain
//   through it without bubbles.
//   A stalled receiver holds the result register; one more item waits in the
//   input register, after which s_axis_tready drops.
//   Reset empties both registers, sets the cursor, shelf height and layer to
//   zero, and both atlas dimensions to 1024.
// ----------------------------------------------------------------------------
module glyph_atlas_shelf_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // glyph input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // glyph_width[12:0], glyph_height[25:13]
  // placement output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // left_x[11:0], top_y[23:12], right_x[35:24],
                                      // bottom_y[47:36], layer_used[55:48]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic [gasp_pkg::DIM_W-1:0] atlas_width_q, atlas_height_q;
  logic                       cfg_wr;

  logic                       in_valid_q, in_valid_d;
  logic [gasp_pkg::DIM_W-1:0] glyph_width_q, glyph_height_q;

  gasp_pkg::place_state_t     state_q, state_d, state_nxt;
  logic                       update;
  gasp_pkg::place_result_t    result_q, result_nxt;
  logic                       out_valid_q, out_valid_d;
  logic                       advance;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q  <= gasp_pkg::ATLAS_DIM_RESET;
      atlas_height_q <= gasp_pkg::ATLAS_DIM_RESET;
    end else if (cfg_wr) begin
      unique case (gasp_pkg::reg_idx_e'(paddr[2]))
        gasp_pkg::REG_ATLAS_WIDTH:  atlas_width_q  <= pwdata[12:0];
        gasp_pkg::REG_ATLAS_HEIGHT: atlas_height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (gasp_pkg::reg_idx_e'(paddr[2]))
      gasp_pkg::REG_ATLAS_WIDTH:  prdata = {19'b0, atlas_width_q};
      gasp_pkg::REG_ATLAS_HEIGHT: prdata = {19'b0, atlas_height_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    if (advance) begin
      out_valid_d = in_valid_q;
      if (in_valid_q && update) begin
        state_d = state_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      glyph_width_q  <= s_axis_tdata[12:0];
      glyph_height_q <= s_axis_tdata[25:13];
    end
    if (advance && in_valid_q) begin
      result_q <= result_nxt;
    end
  end

  // ---------------- placement ----------------
  gasp_place u_place (
    .glyph_width_i  (glyph_width_q),
    .glyph_height_i (glyph_height_q),
    .atlas_width_i  (atlas_width_q),
    .atlas_height_i (atlas_height_q),
    .state_i        (state_q),
    .state_o        (state_nxt),
    .update_o       (update),
    .result_o       (result_nxt)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.status;
  assign m_axis_tdata  = {result_q.layer_used, result_q.bottom_y, result_q.right_x,
                          result_q.top_y, result_q.left_x};

`ifndef SYNTHESIS
  // non-placed items carry no coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != gasp_pkg::ST_PLACED)) |-> (m_axis_tdata == '0))
    else $error("non-placed item has nonzero payload");

  // cursor state only moves when a glyph leaves the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_q && advance) |=> $stable(state_q))
    else $error("placement state changed without a retiring item");

  // a placed rectangle never wraps around its own corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == gasp_pkg::ST_PLACED)) |->
      ((result_q.right_x >= result_q.left_x) && (result_q.bottom_y >= result_q.top_y)))
    else $error("placed rectangle corners out of order");

  // a waiting result is kept while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(result_q)))
    else $error("stalled result lost or changed");
`endif

endmodule

FILE: hdl/gasp_place.sv
// ----------------------------------------------------------------------------
// gasp_place: shelf placement for one glyph
// Decides skip, oversize, shelf wrap, new layer or exhaustion from the
// current cursor state and gives the result item and the next state.
// ----------------------------------------------------------------------------
module gasp_place (
  input  logic [gasp_pkg::DIM_W-1:0] glyph_width_i,
  input  logic [gasp_pkg::DIM_W-1:0] glyph_height_i,
  input  logic [gasp_pkg::DIM_W-1:0] atlas_width_i,
  input  logic [gasp_pkg::DIM_W-1:0] atlas_height_i,
  input  gasp_pkg::place_state_t     state_i,
  output gasp_pkg::place_state_t     state_o,
  output logic                       update_o,
  output gasp_pkg::place_result_t    result_o
);

  localparam logic [gasp_pkg::LAYER_W:0] LayerLimit =
      (gasp_pkg::LAYER_W+1)'(gasp_pkg::MAX_LAYERS);

  logic [12:0] aw, ah;
  logic        empty, oversize, wrap, new_layer, exhausted;
  logic [13:0] x_end;
  logic [12:0] x1, x2;
  logic [14:0] y1;
  logic [15:0] y_end;
  logic [11:0] y2;
  logic [12:0] sh1, sh2;
  logic [7:0]  layer2;
  logic [8:0]  layer_inc;
  logic [12:0] right_sum, bottom_sum;

  always_comb begin
    aw = (atlas_width_i  > gasp_pkg::DIM_LIMIT) ? gasp_pkg::DIM_LIMIT : atlas_width_i;
    ah = (atlas_height_i > gasp_pkg::DIM_LIMIT) ? gasp_pkg::DIM_LIMIT : atlas_height_i;

    empty    = (glyph_width_i == '0) || (glyph_height_i == '0);
    oversize = (glyph_width_i > aw) || (glyph_height_i > ah);

    // horizontal fit, else wrap below the current shelf plus a gap row
    x_end = {1'b0, state_i.cursor_x} + {1'b0, glyph_width_i};
    wrap  = (state_i.cursor_x >= aw) || (x_end > {1'b0, aw});
    x1    = wrap ? '0 : state_i.cursor_x;
    y1    = wrap ? ({1'b0, state_i.cursor_y} + {2'b0, state_i.shelf_height} + 15'd1)
                 : {1'b0, state_i.cursor_y};
    sh1   = (glyph_height_i > state_i.shelf_height) ? glyph_height_i
                                                    : state_i.shelf_height;

    // vertical fit of the (possibly taller) shelf, else a fresh layer
    y_end     = {1'b0, y1} + {3'b0, sh1};
    new_layer = (y1 >= {2'b0, ah}) || (y_end > {3'b0, ah});
    layer_inc = {1'b0, state_i.layer_index} + 9'd1;
    exhausted = new_layer && (layer_inc >= LayerLimit);

    // a kept shelf row lies below ah, so it fits in 12 bits
    x2     = new_layer ? '0 : x1;
    y2     = new_layer ? '0 : y1[11:0];
    sh2    = new_layer ? glyph_height_i : sh1;
    layer2 = new_layer ? layer_inc[7:0] : state_i.layer_index;

    right_sum  = x2 + glyph_width_i - 13'd1;
    bottom_sum = {1'b0, y2} + glyph_height_i - 13'd1;

    update_o = !empty && !oversize && !exhausted;

    state_o.cursor_x     = x2 + glyph_width_i + 13'd1;
    state_o.cursor_y     = {2'b0, y2};
    state_o.shelf_height = sh2;
    state_o.layer_index  = layer2;

    result_o = '0;
    priority if (empty) begin
      result_o.status = gasp_pkg::ST_EMPTY;
    end else if (oversize) begin
      result_o.status = gasp_pkg::ST_OVERSIZE;
    end else if (exhausted) begin
      result_o.status = gasp_pkg::ST_EXHAUSTED;
    end else begin
      result_o.status     = gasp_pkg::ST_PLACED;
      result_o.left_x     = x2[11:0];
      result_o.top_y      = y2;
      result_o.right_x    = right_sum[11:0];
      result_o.bottom_y   = bottom_sum[11:0];
      result_o.layer_used = layer2;
    end
  end

endmodule

FILE: test/tb_glyph_atlas_shelf_packer.sv
// ----------------------------------------------------------------------------
// tb_glyph_atlas_shelf_packer: self-checking testbench for the shelf packer
// Sets the layer size over APB and streams glyph sizes through the packer.
// A scoreboard keeps its own cursor, shelf and layer state, predicts the
// placement of every accepted glyph and compares it with the output items in
// order. Both stream sides idle in random bursts. One phase holds the
// output back long enough to stall the input. The last phase uses a 1x1
// layer to run out of layers.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_shelf_packer;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;     // two-stage pipe plus margin

  class atlas_scoreboard;
    logic [gasp_pkg::DIM_W-1:0]      atlas_w;
    logic [gasp_pkg::DIM_W-1:0]      atlas_h;
    logic [gasp_pkg::DIM_W-1:0]      cur_x;
    logic [gasp_pkg::CURSOR_Y_W-1:0] cur_y;
    logic [gasp_pkg::DIM_W-1:0]      shelf_h;
    logic [gasp_pkg::LAYER_W-1:0]    layer_now;
    gasp_pkg::place_result_t         expected_places[$];
    int unsigned                     errors;

    function new();
      atlas_w   = gasp_pkg::ATLAS_DIM_RESET;
      atlas_h   = gasp_pkg::ATLAS_DIM_RESET;
      cur_x     = '0;
      cur_y     = '0;
      shelf_h   = '0;
      layer_now = '0;
      errors    = 0;
    endfunction

    function void set_dim(gasp_pkg::reg_idx_e idx, logic [gasp_pkg::DIM_W-1:0] val);
      case (idx)
        gasp_pkg::REG_ATLAS_WIDTH:  atlas_w = val;
        gasp_pkg::REG_ATLAS_HEIGHT: atlas_h = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_places.size();
    endfunction

    // Work out where the glyph lands and advance the cursor.
    function void predict_placement(logic [gasp_pkg::DIM_W-1:0] w,
                                    logic [gasp_pkg::DIM_W-1:0] h);
      int unsigned             aw, ah, x, y, sh, lyr, wi, hi;
      int unsigned             rx, by, nx;
      bit                      out_of_layers;
      gasp_pkg::place_result_t r;
      aw = 32'((atlas_w > gasp_pkg::DIM_LIMIT) ? gasp_pkg::DIM_LIMIT : atlas_w);
      ah = 32'((atlas_h > gasp_pkg::DIM_LIMIT) ? gasp_pkg::DIM_LIMIT : atlas_h);
      wi = 32'(w);
      hi = 32'(h);
      r = '0;
      out_of_layers = 1'b0;
      if (wi == 0 || hi == 0) begin
        r.status = gasp_pkg::ST_EMPTY;
      end else if (wi > aw || hi > ah) begin
        r.status = gasp_pkg::ST_OVERSIZE;
      end else begin
        x   = 32'(cur_x);
        y   = 32'(cur_y);
        sh  = 32'(shelf_h);
        lyr = 32'(layer_now);
        if (x >= aw || x + wi > aw) begin
          x = 0;
          y = y + sh + 1;
        end
        // shelf height only grows, even across a wrap
        if (hi > sh) sh = hi;
        if (y >= ah || y + sh > ah) begin
          if (lyr + 1 >= gasp_pkg::MAX_LAYERS) begin
            out_of_layers = 1'b1;
          end else begin
            x   = 0;
            y   = 0;
            lyr = lyr + 1;
            sh  = hi;
          end
        end
        if (out_of_layers) begin
          r.status = gasp_pkg::ST_EXHAUSTED;
        end else begin
          rx = x + wi - 1;
          by = y + hi - 1;
          nx = x + wi + 1;
          r.status     = gasp_pkg::ST_PLACED;
          r.left_x     = x[gasp_pkg::COORD_W-1:0];
          r.top_y      = y[gasp_pkg::COORD_W-1:0];
          r.right_x    = rx[gasp_pkg::COORD_W-1:0];
          r.bottom_y   = by[gasp_pkg::COORD_W-1:0];
          r.layer_used = lyr[gasp_pkg::LAYER_W-1:0];
          cur_x     = nx[gasp_pkg::DIM_W-1:0];
          cur_y     = y[gasp_pkg::CURSOR_Y_W-1:0];
          shelf_h   = sh[gasp_pkg::DIM_W-1:0];
          layer_now = lyr[gasp_pkg::LAYER_W-1:0];
        end
      end
      expected_places = {expected_places, r};
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [55:0] d);
      gasp_pkg::place_result_t e;
      if (expected_places.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual status %0d data %h",
                 $time, st, d);
        return;
      end
      e = expected_places.pop_front();
      cmp_field("status",     32'(e.status),     32'(st));
      cmp_field("left_x",     32'(e.left_x),     32'(d[11:0]));
      cmp_field("top_y",      32'(e.top_y),      32'(d[23:12]));
      cmp_field("right_x",    32'(e.right_x),    32'(d[35:24]));
      cmp_field("bottom_y",   32'(e.bottom_y),   32'(d[47:36]));
      cmp_field("layer_used", 32'(e.layer_used), 32'(d[55:48]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // glyph_width[12:0], glyph_height[25:13]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // left_x[11:0], top_y[23:12], right_x[35:24],
                               // bottom_y[47:36], layer_used[55:48]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  atlas_scoreboard sb;
  int unsigned     rx_idle_pct;
  int unsigned     rx_hold_len;
  int unsigned     rx_hold_seq;
  int unsigned     cycle_count = 0;

  glyph_atlas_shelf_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Output side: ready stretches, random stalls, and a requested long hold.
  initial begin
    int unsigned n;
    int unsigned hold_seen;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_seq != hold_seen) begin
        hold_seen = rx_hold_seq;
        n = rx_hold_len;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Mostly small glyphs, some up to the full layer, some empty or oversized.
  function automatic logic [gasp_pkg::DIM_W-1:0] pick_dim(int unsigned lim, bit big_ok);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 4) v = 0;
    else if (lim == 0) v = $urandom_range(1, 8191);
    else if (r < 9) v = $urandom_range(lim + 1, 8191);
    else if (r < 17 && big_ok) v = $urandom_range(1, lim);
    else v = $urandom_range(1, (lim < 48) ? lim : 48);
    return v[gasp_pkg::DIM_W-1:0];
  endfunction

  function automatic int unsigned clamp_dim(logic [gasp_pkg::DIM_W-1:0] v);
    return 32'((v > gasp_pkg::DIM_LIMIT) ? gasp_pkg::DIM_LIMIT : v);
  endfunction

  task automatic offer_glyph(logic [gasp_pkg::DIM_W-1:0] w, logic [gasp_pkg::DIM_W-1:0] h,
                             int unsigned gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, h, w};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_placement(w, h);
  endtask

  // Stop offering and let every outstanding item come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write a register, then read it back.
  task automatic apb_write(gasp_pkg::reg_idx_e idx, logic [gasp_pkg::DIM_W-1:0] val);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {19'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_dim(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {19'b0, val}) begin
      sb.errors++;
      $display("%0t: register %s readback, expected %0d, actual %0d",
               $time, idx.name(), val, got);
    end
  endtask

  task automatic run_phase(logic [gasp_pkg::DIM_W-1:0] aw, logic [gasp_pkg::DIM_W-1:0] ah,
                           int unsigned n, int unsigned gap_pct, int unsigned hold_len);
    settle();
    apb_write(gasp_pkg::REG_ATLAS_WIDTH, aw);
    apb_write(gasp_pkg::REG_ATLAS_HEIGHT, ah);
    rx_idle_pct = gap_pct;
    if (hold_len != 0) begin
      rx_hold_len = hold_len;
      rx_hold_seq++;
    end
    for (int unsigned i = 0; i < n; i++) begin
      // keep big glyphs from using up the layers before the last phase
      offer_glyph(pick_dim(clamp_dim(aw), sb.layer_now < 150),
                  pick_dim(clamp_dim(ah), sb.layer_now < 150), gap_pct);
    end
  endtask

  initial begin
    sb = new();
    rx_idle_pct   = 20;
    rx_hold_len   = 0;
    rx_hold_seq   = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layer size 1024x1024: empties, exact fit, wrap, oversize, new layer
    offer_glyph(13'd0, 13'd0, 0);
    offer_glyph(13'd0, 13'd8191, 0);
    offer_glyph(13'd8191, 13'd0, 0);
    offer_glyph(13'd1, 13'd1, 0);
    offer_glyph(13'd1024, 13'd1, 0);
    offer_glyph(13'd1025, 13'd1, 0);
    offer_glyph(13'd1, 13'd1025, 0);
    offer_glyph(13'd8191, 13'd8191, 0);
    offer_glyph(13'd1024, 13'd1024, 0);
    offer_glyph(13'd5, 13'd7, 20);
    offer_glyph(13'd4096, 13'd1, 20);
    offer_glyph(13'd6826, 13'd1365, 20);
    settle();
    apb_write(gasp_pkg::REG_ATLAS_WIDTH, 13'd4096);
    apb_write(gasp_pkg::REG_ATLAS_HEIGHT, 13'd4096);
    offer_glyph(13'd4096, 13'd4096, 0);
    offer_glyph(13'd4097, 13'd1, 0);
    offer_glyph(13'd1, 13'd4096, 0);
    offer_glyph(13'd4096, 13'd1, 0);
    // width above the limit acts as 4096, zero height rejects everything
    settle();
    apb_write(gasp_pkg::REG_ATLAS_WIDTH, 13'd8191);
    apb_write(gasp_pkg::REG_ATLAS_HEIGHT, 13'd0);
    offer_glyph(13'd5, 13'd5, 0);
    offer_glyph(13'd0, 13'd3, 0);
    settle();
    apb_write(gasp_pkg::REG_ATLAS_WIDTH, 13'd1);
    apb_write(gasp_pkg::REG_ATLAS_HEIGHT, 13'd1);
    offer_glyph(13'd1, 13'd1, 0);
    offer_glyph(13'd1, 13'd1, 0);
    offer_glyph(13'd2, 13'd1, 0);

    run_phase(13'd1024, 13'd1024, 350, 25, 0);
    run_phase(13'd4096, 13'd4096, 250, 0, 0);
    run_phase(13'd8191, 13'd300, 150, 15, 0);
    run_phase(13'd16, 13'd16, 60, 40, 0);
    run_phase(13'd1, 13'd4096, 80, 10, 0);
    run_phase(13'd300, 13'd7, 80, 30, 0);
    run_phase(13'd4095, 13'd2048, 250, 20, 0);
    run_phase(13'd0, 13'd1024, 30, 20, 0);
    // long output hold while the input keeps offering
    run_phase(13'd1024, 13'd1024, 350, 5, 300);
    // one glyph per layer until the layers run out; no idling from here on
    run_phase(13'd1, 13'd1, 300, 0, 0);

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
